### design/bssc_pkg.sv
`timescale 1ns / 1ps

package bssc_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned PctW      = 7;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned HallW     = 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned NumPhases = 3;

  localparam logic [IntervalW-1:0] RampIntervalRst = 16'd70;
  localparam logic [PctW-1:0]      StartHighRst    = 7'd25;
  localparam logic [PctW-1:0]      StartLowRst     = 7'd50;
  localparam logic [PctW-1:0]      MaxDutyRst      = 7'd99;

  localparam logic [DutyW-1:0] FullPct   = 8'd100;
  localparam logic [DutyW-1:0] FullScale = 8'd255;
  // ceil(2^19 / 100): exact floor division by 100 for values below 43690
  localparam logic [12:0]      Recip100  = 13'd5243;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRampInterval = 8'd0,
    CfgStartHigh    = 8'd1,
    CfgStartLow     = 8'd2,
    CfgMaxDuty      = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IntervalW-1:0] ramp_interval_ms;
    logic [PctW-1:0]      start_duty_mode_high;
    logic [PctW-1:0]      start_duty_mode_low;
    logic [PctW-1:0]      max_duty;
  } cfg_t;

  typedef struct packed {
    logic [HallW-1:0] hall_code;
    logic             pedal_front_level;
    logic             pedal_rear_level;
    logic             override_level;
    logic             mode_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [HallW-1:0] hi_mask;
    logic [1:0]       lo_idx;
  } hall_dec_t;

  // (p * 255) / 100, saturated at 255
  function automatic logic [DutyW-1:0] scale_percent(input logic [DutyW-1:0] p);
    logic [15:0] x;
    logic [28:0] prod;
    begin
      x    = {p, 8'd0} - {8'd0, p};
      prod = 29'(x[14:0] * Recip100);
      if (p >= FullPct) begin
        scale_percent = FullScale;
      end else begin
        scale_percent = prod[26:19];
      end
    end
  endfunction

  function automatic hall_dec_t hall_decode(input logic [HallW-1:0] code);
    hall_dec_t d;
    begin
      d = '{valid: 1'b1, hi_mask: 3'b000, lo_idx: 2'd0};
      case (code)
        3'd5: begin d.hi_mask = 3'b001; d.lo_idx = 2'd1; end
        3'd1: begin d.hi_mask = 3'b100; d.lo_idx = 2'd1; end
        3'd3: begin d.hi_mask = 3'b100; d.lo_idx = 2'd0; end
        3'd2: begin d.hi_mask = 3'b010; d.lo_idx = 2'd0; end
        3'd6: begin d.hi_mask = 3'b010; d.lo_idx = 2'd2; end
        3'd4: begin d.hi_mask = 3'b001; d.lo_idx = 2'd2; end
        default: d.valid = 1'b0;
      endcase
      hall_decode = d;
    end
  endfunction

endpackage

### design/bssc_cfg_regs.sv
`timescale 1ns / 1ps

module bssc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bssc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bssc_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              cfg_ready_o,
  output bssc_pkg::cfg_t                    cfg_o
);

  bssc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bssc_pkg::CfgRampInterval: cfg_d.ramp_interval_ms     = cfg_data_i;
        bssc_pkg::CfgStartHigh:    cfg_d.start_duty_mode_high = cfg_data_i[bssc_pkg::PctW-1:0];
        bssc_pkg::CfgStartLow:     cfg_d.start_duty_mode_low  = cfg_data_i[bssc_pkg::PctW-1:0];
        bssc_pkg::CfgMaxDuty:      cfg_d.max_duty             = cfg_data_i[bssc_pkg::PctW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_interval_ms     <= bssc_pkg::RampIntervalRst;
      cfg_q.start_duty_mode_high <= bssc_pkg::StartHighRst;
      cfg_q.start_duty_mode_low  <= bssc_pkg::StartLowRst;
      cfg_q.max_duty             <= bssc_pkg::MaxDutyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/bssc_ramp.sv
`timescale 1ns / 1ps

module bssc_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  bssc_pkg::item_t               item_i,
  input  bssc_pkg::cfg_t                cfg_i,
  output logic [bssc_pkg::DutyW-1:0]    duty_o
);

  logic [bssc_pkg::PctW-1:0]  ramp_q, ramp_d;
  logic [bssc_pkg::TimeW-1:0] last_q, last_d;
  logic                       prev_mode_q;

  logic [bssc_pkg::PctW-1:0]  ramp_base;
  logic [bssc_pkg::PctW-1:0]  start;
  logic [bssc_pkg::PctW-1:0]  headroom;
  logic [bssc_pkg::TimeW-1:0] elapsed;
  logic                       run;
  logic                       can_rise;
  logic                       due;

  always_comb begin
    ramp_base = (item_i.mode_level != prev_mode_q) ? '0 : ramp_q;
    start     = item_i.mode_level ? cfg_i.start_duty_mode_high : cfg_i.start_duty_mode_low;
    run       = (!item_i.pedal_rear_level && item_i.pedal_front_level) ||
                !item_i.override_level;
    headroom  = cfg_i.max_duty - start;
    can_rise  = (start < cfg_i.max_duty) && (ramp_base < headroom);
    elapsed   = item_i.now_ms - last_q;
    due       = elapsed >= {{(bssc_pkg::TimeW-bssc_pkg::IntervalW){1'b0}},
                            cfg_i.ramp_interval_ms};
    ramp_d    = ramp_base;
    last_d    = last_q;
    duty_o    = '0;
    if (run) begin
      if (can_rise && due) begin
        ramp_d = ramp_base + 1'b1;
        last_d = item_i.now_ms;
      end
      duty_o = bssc_pkg::scale_percent({1'b0, ramp_d} + {1'b0, start});
    end else begin
      ramp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_q      <= '0;
      last_q      <= '0;
      prev_mode_q <= 1'b0;
    end else if (adv_i) begin
      ramp_q      <= ramp_d;
      last_q      <= last_d;
      prev_mode_q <= item_i.mode_level;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_clears_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !run |=> ramp_q == '0)
    else $error("ramp not cleared when run condition drops");

  a_ramp_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && run && item_i.mode_level == prev_mode_q |=>
      ramp_q == $past(ramp_q) || ramp_q == $past(ramp_q) + 1'b1)
    else $error("ramp moved by more than one step");
`endif

endmodule

### design/bssc_commute.sv
`timescale 1ns / 1ps

module bssc_commute (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [bssc_pkg::HallW-1:0]    hall_code_i,
  input  logic [bssc_pkg::DutyW-1:0]    duty_i,
  output logic [bssc_pkg::HallW-1:0]    high_side_mask_o,
  output logic [bssc_pkg::DutyW-1:0]    low_duty_o [bssc_pkg::NumPhases]
);

  bssc_pkg::hall_dec_t        dec;
  logic [bssc_pkg::HallW-1:0] mask_q;
  logic [bssc_pkg::DutyW-1:0] duty_q [bssc_pkg::NumPhases];
  logic [bssc_pkg::DutyW-1:0] duty_d [bssc_pkg::NumPhases];
  logic [bssc_pkg::NumPhases-1:0] live;

  always_comb begin
    dec = bssc_pkg::hall_decode(hall_code_i);
    for (int i = 0; i < bssc_pkg::NumPhases; i++) begin
      duty_d[i] = (dec.lo_idx == 2'(i)) ? duty_i : '0;
      live[i]   = duty_q[i] != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      for (int i = 0; i < bssc_pkg::NumPhases; i++) begin
        duty_q[i] <= '0;
      end
    end else if (adv_i && dec.valid) begin
      mask_q <= dec.hi_mask;
      for (int i = 0; i < bssc_pkg::NumPhases; i++) begin
        duty_q[i] <= duty_d[i];
      end
    end
  end

  assign high_side_mask_o = mask_q;
  assign low_duty_o       = duty_q;

`ifndef NO_ASSERTIONS
  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(mask_q))
    else $error("more than one high-side gate on");

  a_single_low_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(live) <= 1)
    else $error("more than one low-side phase driven");
`endif

endmodule

### design/bldc_six_step_commutator_top.sv
`timescale 1ns / 1ps
// Path: an accepted word waits in the input register and, once the output is free,
// advances into the result registers; the ramp update and duty scale are combinational.
// Throughput: one word per cycle unless the output stalls.
// Stall on the output backs up through one input register stage only.
// Reset (rst_ni low, async): ramp, timestamp and gates clear, registers take defaults.

module bldc_six_step_commutator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bssc_pkg::HallW-1:0]        hall_code_i,
  input  logic                              pedal_front_level_i,
  input  logic                              pedal_rear_level_i,
  input  logic                              override_level_i,
  input  logic                              mode_level_i,
  input  logic [bssc_pkg::TimeW-1:0]        now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bssc_pkg::HallW-1:0]        high_side_mask_o,
  output logic [bssc_pkg::DutyW-1:0]        low_duty_a_o,
  output logic [bssc_pkg::DutyW-1:0]        low_duty_b_o,
  output logic [bssc_pkg::DutyW-1:0]        low_duty_c_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bssc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bssc_pkg::CfgDataW-1:0]     cfg_data_i
);

  bssc_pkg::cfg_t             cfg;
  bssc_pkg::item_t            item_q;
  logic                       item_valid_q, item_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;
  logic                       adv;
  logic                       in_fire;
  logic [bssc_pkg::DutyW-1:0] duty;
  logic [bssc_pkg::DutyW-1:0] low_duty [bssc_pkg::NumPhases];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_fire) begin
      item_valid_d = 1'b1;
    end else if (adv) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.hall_code         <= hall_code_i;
      item_q.pedal_front_level <= pedal_front_level_i;
      item_q.pedal_rear_level  <= pedal_rear_level_i;
      item_q.override_level    <= override_level_i;
      item_q.mode_level        <= mode_level_i;
      item_q.now_ms            <= now_ms_i;
    end
  end

  bssc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  bssc_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .duty_o (duty)
  );

  bssc_commute u_commute (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .hall_code_i      (item_q.hall_code),
    .duty_i           (duty),
    .high_side_mask_o (high_side_mask_o),
    .low_duty_o       (low_duty)
  );

  assign out_valid_o  = out_valid_q;
  assign low_duty_a_o = low_duty[0];
  assign low_duty_b_o = low_duty[1];
  assign low_duty_c_o = low_duty[2];

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while pipeline has room");

  a_result_follows_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("advanced word produced no result");
`endif

endmodule
